// ===== hdl/mdrg_pkg.sv =====
// shared types and constants for the mic dc removal, gate and gain block
package mdrg_pkg;

   localparam int FRAC_BITS = 20;
   localparam int RAW_W     = 12;
   localparam int OFS_W     = 32;
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 17;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_THR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_THR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING  = 2'd3;

   localparam logic [9:0]  GAIN_RST      = 10'd150;
   localparam logic [11:0] GATE_THR_RST  = 12'd15;
   localparam logic [11:0] LEVEL_THR_RST = 12'd40;
   localparam logic [15:0] SMOOTHING_RST = 16'd66;

   localparam logic [OFS_W-1:0] OFFSET_RST = {12'd1500, 20'd0};
   localparam logic [OFS_W-1:0] OFFSET_MAX = {12'd4095, 20'd0};

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      logic [11:0] raw_sample;
      logic        muted;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic [31:0]        stereo_word;
      logic               level_indicator;
      logic               mute_drive;
   } rsp_type;

endpackage

// ===== hdl/mdrg_mul.sv =====
// shared signed multiplier with registered product
module mdrg_mul (
   input  logic                                   clock,
   input  logic                                   mul_en,
   input  logic signed [mdrg_pkg::MUL_A_W-1:0]    op_a,
   input  logic signed [mdrg_pkg::MUL_B_W-1:0]    op_b,
   output logic signed [mdrg_pkg::PROD_W-1:0]     prod
);
   import mdrg_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (mul_en) begin
         prod_in = PROD_W'(op_a) * PROD_W'(op_b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/mic_dc_remove_gate_gain_core.sv =====
// top level: dc offset tracking, level indicator, noise gate and saturating gain
// each item passes through MUL1, UPD, MAG, MUL2 and SAT, which holds it until the output is free
// a new item is taken only in IDLE; the single multiplier is used twice per item
// (offset step, then gain) and the offset must be updated before the next item
// reset (synchronous): offset back to 1500.0, block position and indicator to zero,
// registers to their defaults, no item in flight and no result pending
module mic_dc_remove_gate_gain_core #(
   parameter int BLOCK_LEN = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mdrg_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mdrg_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [mdrg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mdrg_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import mdrg_pkg::*;

   localparam int POS_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_MAG  = 3'd3;
   localparam logic [2:0] ST_MUL2 = 3'd4;
   localparam logic [2:0] ST_SAT  = 3'd5;

   // configuration
   logic [9:0]  gain_ff, gain_in;
   logic [11:0] gate_thr_ff, gate_thr_in;
   logic [11:0] level_thr_ff, level_thr_in;
   logic [15:0] smoothing_ff, smoothing_in;

   // control and state
   logic [2:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ind_ff, ind_in;
   logic [OFS_W-1:0] offset_ff, offset_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // item datapath
   logic                     muted_ff, muted_in;
   logic                     last_ff, last_in;
   logic signed [OFS_W:0]    diff_ff, diff_in;
   logic signed [OFS_W:0]    c_ff, c_in;
   logic [OFS_W-1:0]         mag_ff, mag_in;
   rsp_type                  rsp_ff, rsp_in;

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0]  prod;
   logic                      mul_en;

   logic                      accept;
   logic                      out_free;
   logic signed [OFS_W:0]     delta;
   logic signed [OFS_W:0]     ofs_sum;
   logic signed [OFS_W:0]     c_abs;
   logic [21:0]               amp;
   logic                      gated;
   logic                      loud;
   logic [15:0]               sample;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // floor(diff * alpha / 2^16) is an arithmetic shift of the product
   assign delta   = prod[OFS_W+16:16];
   assign ofs_sum = $signed({1'b0, offset_ff}) + delta;
   assign c_abs   = c_ff[OFS_W] ? -c_ff : c_ff;
   assign amp     = prod[FRAC_BITS+21:FRAC_BITS];
   assign gated   = mag_ff < {gate_thr_ff, 20'd0};
   assign loud    = mag_ff > {level_thr_ff, 20'd0};

   assign mul_en = (state_ff == ST_MUL1) || (state_ff == ST_MUL2);
   assign op_a   = (state_ff == ST_MUL1) ? diff_ff : $signed({1'b0, mag_ff});
   assign op_b   = (state_ff == ST_MUL1) ? $signed({1'b0, smoothing_ff})
                                         : $signed({7'd0, gain_ff});

   mdrg_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod   (prod)
   );

   // restore sign and saturate; the sample is zero when muted or gated
   always_comb begin
      sample = 16'd0;
      if (!muted_ff && !gated) begin
         if (c_ff[OFS_W]) begin
            sample = (amp > 22'd32768) ? SAMPLE_MIN : 16'(-amp);
         end else begin
            sample = (amp > 22'd32767) ? SAMPLE_MAX : amp[15:0];
         end
      end
   end

   always_comb begin
      gain_in      = gain_ff;
      gate_thr_in  = gate_thr_ff;
      level_thr_in = level_thr_ff;
      smoothing_in = smoothing_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN:      gain_in      = csr_wdata[9:0];
            CSR_GATE_THR:  gate_thr_in  = csr_wdata[11:0];
            CSR_LEVEL_THR: level_thr_in = csr_wdata[11:0];
            CSR_SMOOTHING: smoothing_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      ind_in       = ind_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff;
      muted_in     = muted_ff;
      last_in      = last_ff;
      diff_in      = diff_ff;
      c_in         = c_ff;
      mag_in       = mag_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               muted_in = req_data.muted;
               last_in  = (pos_ff == POS_LAST);
               pos_in   = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
               diff_in  = $signed({1'b0, req_data.raw_sample, 20'd0})
                        - $signed({1'b0, offset_ff});
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_UPD;
         ST_UPD: begin
            // the new offset always lies between the old one and the sample
            if (!muted_ff) begin
               offset_in = ofs_sum[OFS_W-1:0];
            end
            c_in     = diff_ff - delta;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            mag_in   = c_abs[OFS_W-1:0];
            state_in = ST_MUL2;
         end
         ST_MUL2: state_in = ST_SAT;
         ST_SAT: begin
            if (out_free) begin
               if (muted_ff) begin
                  ind_in = 1'b0;
               end else if (last_ff) begin
                  ind_in = loud;
               end
               rsp_in.sample_out      = sample;
               rsp_in.stereo_word     = {sample, sample};
               rsp_in.level_indicator = muted_ff ? 1'b0 : (last_ff ? loud : ind_ff);
               rsp_in.mute_drive      = muted_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RST;
         gate_thr_ff  <= GATE_THR_RST;
         level_thr_ff <= LEVEL_THR_RST;
         smoothing_ff <= SMOOTHING_RST;
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         ind_ff       <= 1'b0;
         offset_ff    <= OFFSET_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         gate_thr_ff  <= gate_thr_in;
         level_thr_ff <= level_thr_in;
         smoothing_ff <= smoothing_in;
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         ind_ff       <= ind_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      muted_ff <= muted_in;
      last_ff  <= last_in;
      diff_ff  <= diff_in;
      c_ff     <= c_in;
      mag_ff   <= mag_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= OFFSET_MAX)
      else $error("offset estimate left the converter range");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("item accepted while another is in flight");

   a_muted_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.mute_drive) |->
         (rsp_ff.sample_out == 16'sd0) && !rsp_ff.level_indicator)
      else $error("muted item gave a nonzero sample or indicator");

   a_muted_holds_offset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && muted_ff) |=> $stable(offset_ff))
      else $error("offset moved on a muted item");

   a_sat_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAT && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished item was not presented");

endmodule
